>>> hw/rtl/msdp_pkg.sv
// ----------------------------------------------------------------------------
// msdp_pkg: shared definitions for the 3x3 matrix sum/diff/product block
// Default sizes, fixed result field widths and the control word that goes
// with each read issued to the matrix stores.
// ----------------------------------------------------------------------------
`default_nettype none

package msdp_pkg;

  // default matrix dimension and element width
  localparam int unsigned DIM_DEF        = 3;
  localparam int unsigned ELEM_WIDTH_DEF = 16;

  // result field widths
  localparam int unsigned ROW_W  = 2;
  localparam int unsigned COL_W  = 2;
  localparam int unsigned SUM_W  = 17;
  localparam int unsigned DIFF_W = 17;
  localparam int unsigned PROD_W = 33;

  // control word that travels with one read through the mac pipeline
  typedef struct packed {
    logic vld;    // read issued this cycle
    logic first;  // first term of the dot product
    logic last;   // last term of the dot product
    logic cap_a;  // this A read is the A entry at the result position
    logic cap_b;  // this B read is the B entry at the result position
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/msdp_if.sv
// ----------------------------------------------------------------------------
// msdp_if: valid/ready channels of the matrix sum/diff/product block
// Element input channel and result output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface msdp_in_if
  import msdp_pkg::*;
#(
  parameter int unsigned ELEM_W = ELEM_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface msdp_out_if
  import msdp_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic        [ROW_W-1:0]  row_index;
  logic        [COL_W-1:0]  col_index;
  logic signed [SUM_W-1:0]  sum_value;
  logic signed [DIFF_W-1:0] diff_value;
  logic signed [PROD_W-1:0] product_value;
  logic                     last_entry;

  modport source (output valid, output row_index, output col_index, output sum_value,
                  output diff_value, output product_value, output last_entry,
                  input ready);
  modport sink   (input valid, input row_index, input col_index, input sum_value,
                  input diff_value, input product_value, input last_entry,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/msdp_store.sv
// ----------------------------------------------------------------------------
// msdp_store: matrix element memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module msdp_store
  import msdp_pkg::*;
#(
  parameter int unsigned DEPTH  = DIM_DEF * DIM_DEF,
  parameter int unsigned WIDTH  = ELEM_WIDTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire        [ADDR_W-1:0] wr_addr,
  input  wire  signed [WIDTH-1:0] wr_data,
  input  wire                     rd_en,
  input  wire        [ADDR_W-1:0] rd_addr,
  output logic signed [WIDTH-1:0] rd_data
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/msdp_mac.sv
// ----------------------------------------------------------------------------
// msdp_mac: multiply-accumulate datapath
// Takes the registered store outputs, forms one product per cycle, sums the
// dot product and captures the A and B entries for the sum and difference.
// ----------------------------------------------------------------------------
`default_nettype none

module msdp_mac
  import msdp_pkg::*;
#(
  parameter int unsigned DIM        = DIM_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  mac_ctrl_t                      ctrl,
  input  wire  signed [ELEM_WIDTH-1:0]   rdata_a,
  input  wire  signed [ELEM_WIDTH-1:0]   rdata_b,
  output logic                           done,
  output logic signed [SUM_W-1:0]        sum_o,
  output logic signed [DIFF_W-1:0]       diff_o,
  output logic signed [PROD_W-1:0]       prod_o
);

  localparam int unsigned MUL_W   = 2 * ELEM_WIDTH;
  localparam int unsigned ACC_RAW = MUL_W + $clog2(DIM) + 1;
  localparam int unsigned ACC_W   = (ACC_RAW > PROD_W) ? ACC_RAW : PROD_W;
  localparam int unsigned SD_RAW  = ELEM_WIDTH + 1;
  localparam int unsigned SD_W    = (SD_RAW > SUM_W) ? SD_RAW : SUM_W;

  mac_ctrl_t               s1_r;
  mac_ctrl_t               s2_r;
  logic signed [MUL_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ELEM_WIDTH-1:0] a_cell_r;
  logic signed [ELEM_WIDTH-1:0] b_cell_r;
  logic                    done_r;
  logic signed [SD_W-1:0]  sum_wide;
  logic signed [SD_W-1:0]  diff_wide;

  // control pipeline, aligned to read data and product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      s2_r   <= '0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= ctrl;
      s2_r   <= s1_r;
      done_r <= s2_r.vld & s2_r.last;
    end
  end

  // multiply stage and capture of the elementwise operands
  always_ff @(posedge clk) begin
    if (s1_r.vld) begin
      prod_r <= rdata_a * rdata_b;
    end
    if (s1_r.vld && s1_r.cap_a) begin
      a_cell_r <= rdata_a;
    end
    if (s1_r.vld && s1_r.cap_b) begin
      b_cell_r <= rdata_b;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (s2_r.vld) begin
      if (s2_r.first) begin
        acc_r <= ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  // elementwise sum and difference, wrapped to the field widths
  assign sum_wide  = SD_W'(a_cell_r) + SD_W'(b_cell_r);
  assign diff_wide = SD_W'(a_cell_r) - SD_W'(b_cell_r);

  assign sum_o  = sum_wide[SUM_W-1:0];
  assign diff_o = diff_wide[DIFF_W-1:0];
  assign prod_o = acc_r[PROD_W-1:0];
  assign done   = done_r;

endmodule

`default_nettype wire

>>> hw/rtl/matrix_sum_diff_product_3x3.sv
// ----------------------------------------------------------------------------
// matrix_sum_diff_product_3x3: matrix sum, difference and product
// Loads A and B element by element, then streams A+B, A-B and A*B entries.
//
// Usage:
//   in_ch  : valid/ready stream of signed elements. The first DIM*DIM
//            transfers fill A row by row, the next DIM*DIM fill B.
//   out_ch : valid/ready stream of DIM*DIM results in row-major order, each
//            with row, column, A+B, A-B, the A*B dot product and a last flag.
//   in_ch.ready is low from the transfer that completes B until the last
//   result is in the output register. Each result then takes DIM reads of
//   the two stores (one read port each), one product per cycle, then
//   multiply, accumulate and output register stages; the reads for the
//   next result start only after the current one is in the output register.
//   A stalled receiver holds the current result in the output register and
//   the sequencer waits; nothing is dropped. The final result may wait there
//   while loading of the next A already proceeds.
//   Reset clears the load counter, the sequencer and the output valid; the
//   stores are not cleared, results only appear after both are written.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_sum_diff_product_3x3
  import msdp_pkg::*;
#(
  parameter int unsigned DIM        = DIM_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  msdp_in_if.sink      in_ch,
  msdp_out_if.source   out_ch
);

  localparam int unsigned CELLS  = DIM * DIM;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(2 * CELLS);
  localparam int unsigned IDX_W  = $clog2(DIM);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_CALC = 4'b0010,
    S_WAIT = 4'b0100,
    S_HOLD = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [IDX_W-1:0]   row_r, row_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;

  logic               in_xfer;
  logic               load_a;
  logic               load_b;
  logic               issue;
  logic               k_last;
  logic               entry_last;
  logic               slot_free;
  logic               out_load;
  logic [ADDR_W-1:0]  wr_addr_a;
  logic [ADDR_W-1:0]  wr_addr_b;
  logic [ADDR_W-1:0]  rd_addr_a;
  logic [ADDR_W-1:0]  rd_addr_b;
  logic signed [ELEM_WIDTH-1:0] rdata_a;
  logic signed [ELEM_WIDTH-1:0] rdata_b;
  mac_ctrl_t          ctrl;
  logic               mac_done;
  logic signed [SUM_W-1:0]  mac_sum;
  logic signed [DIFF_W-1:0] mac_diff;
  logic signed [PROD_W-1:0] mac_prod;

  logic                     out_valid_r, out_valid_nxt;
  logic        [ROW_W-1:0]  out_row_r;
  logic        [COL_W-1:0]  out_col_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic signed [DIFF_W-1:0] out_diff_r;
  logic signed [PROD_W-1:0] out_prod_r;
  logic                     out_last_r;

  // load path
  assign in_ch.ready = (state_r == S_LOAD);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign load_a      = in_xfer & (load_cnt_r < CNT_W'(CELLS));
  assign load_b      = in_xfer & ~(load_cnt_r < CNT_W'(CELLS));
  assign wr_addr_a   = load_cnt_r[ADDR_W-1:0];
  assign wr_addr_b   = ADDR_W'(load_cnt_r - CNT_W'(CELLS));

  // read addresses: A row r term k, B term k column c
  assign issue      = (state_r == S_CALC);
  assign k_last     = (k_r == IDX_W'(DIM - 1));
  assign entry_last = (row_r == IDX_W'(DIM - 1)) & (col_r == IDX_W'(DIM - 1));
  assign rd_addr_a  = ADDR_W'(row_r * DIM + k_r);
  assign rd_addr_b  = ADDR_W'(k_r * DIM + col_r);

  // control word for the mac pipeline
  always_comb begin
    ctrl       = '0;
    ctrl.vld   = issue;
    ctrl.first = (k_r == '0);
    ctrl.last  = k_last;
    ctrl.cap_a = (k_r == col_r);
    ctrl.cap_b = (k_r == row_r);
  end

  // output slot
  assign slot_free = ~out_valid_r | out_ch.ready;
  assign out_load  = (state_r == S_HOLD) & slot_free;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    k_nxt        = k_r;
    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (load_cnt_r == CNT_W'(2 * CELLS - 1)) begin
            load_cnt_nxt = '0;
            state_nxt    = S_CALC;
          end else begin
            load_cnt_nxt = load_cnt_r + CNT_W'(1);
          end
        end
      end
      S_CALC: begin
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          if (entry_last) begin
            row_nxt   = '0;
            col_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_CALC;
            if (col_r == IDX_W'(DIM - 1)) begin
              col_nxt = '0;
              row_nxt = row_r + IDX_W'(1);
            end else begin
              col_nxt = col_r + IDX_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= ROW_W'(row_r);
      out_col_r  <= COL_W'(col_r);
      out_sum_r  <= mac_sum;
      out_diff_r <= mac_diff;
      out_prod_r <= mac_prod;
      out_last_r <= entry_last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.row_index     = out_row_r;
  assign out_ch.col_index     = out_col_r;
  assign out_ch.sum_value     = out_sum_r;
  assign out_ch.diff_value    = out_diff_r;
  assign out_ch.product_value = out_prod_r;
  assign out_ch.last_entry    = out_last_r;

  // matrix stores
  msdp_store #(
    .DEPTH (CELLS),
    .WIDTH (ELEM_WIDTH)
  ) u_store_a (
    .clk     (clk),
    .wr_en   (load_a),
    .wr_addr (wr_addr_a),
    .wr_data (in_ch.element_value),
    .rd_en   (issue),
    .rd_addr (rd_addr_a),
    .rd_data (rdata_a)
  );

  msdp_store #(
    .DEPTH (CELLS),
    .WIDTH (ELEM_WIDTH)
  ) u_store_b (
    .clk     (clk),
    .wr_en   (load_b),
    .wr_addr (wr_addr_b),
    .wr_data (in_ch.element_value),
    .rd_en   (issue),
    .rd_addr (rd_addr_b),
    .rd_data (rdata_b)
  );

  // multiply-accumulate datapath
  msdp_mac #(
    .DIM        (DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .done    (mac_done),
    .sum_o   (mac_sum),
    .diff_o  (mac_diff),
    .prod_o  (mac_prod)
  );

endmodule

`default_nettype wire

>>> hw/rtl/msdp_checker.sv
// ----------------------------------------------------------------------------
// msdp_checker: port-level checks for the matrix sum/diff/product block
// Watches the channel ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module msdp_port_checks
  import msdp_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              in_ready,
  input wire              out_valid,
  input wire              out_ready,
  input wire [ROW_W-1:0]  out_row,
  input wire [COL_W-1:0]  out_col,
  input wire              out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // the last flag marks the bottom-right entry only
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == ((out_row == ROW_W'(DIM_DEF - 1)) &&
                                (out_col == COL_W'(DIM_DEF - 1)))))
    else $error("last flag on wrong entry");

  // no element is taken while results of the current pair are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input accepted during result stream");

  // no result right after a reset cycle
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_sum_diff_product_3x3 msdp_port_checks u_msdp_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_row   (out_ch.row_index),
  .out_col   (out_ch.col_index),
  .out_last  (out_ch.last_entry)
);

`default_nettype wire

>>> tb/msdp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdp_checker: scoreboard for the 3x3 matrix sum/diff/product block
// Watches both channels, rebuilds A and B from the element transfers and,
// when B is complete, predicts the nine result entries. Each result transfer
// is compared field by field against the oldest predicted entry.
// ----------------------------------------------------------------------------
module msdp_checker
  import msdp_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  msdp_in_if   in_mon,
  msdp_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);

  localparam int unsigned CELLS = DIM_DEF * DIM_DEF;

  typedef struct {
    logic        [ROW_W-1:0]  row;
    logic        [COL_W-1:0]  col;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic                     last;
  } matrix_entry_t;

  matrix_entry_t                     matrix_entries_q[$];
  logic signed [ELEM_WIDTH_DEF-1:0]  mat_a [CELLS];
  logic signed [ELEM_WIDTH_DEF-1:0]  mat_b [CELLS];
  int unsigned                       elems_loaded = 0;

  always @(posedge clk) begin : matrix_predict
    int unsigned   idx;
    longint        dot;
    matrix_entry_t ent;

    // element transfer: fill A, then B; a full B yields nine entries
    if (rst_n && in_mon.valid && in_mon.ready) begin
      if (elems_loaded < CELLS) begin
        mat_a[elems_loaded] = in_mon.element_value;
      end else begin
        mat_b[elems_loaded - CELLS] = in_mon.element_value;
      end
      elems_loaded++;
      if (elems_loaded == 2 * CELLS) begin
        for (int r = 0; r < DIM_DEF; r++) begin
          for (int c = 0; c < DIM_DEF; c++) begin
            idx = r * DIM_DEF + c;
            dot = 0;
            for (int k = 0; k < DIM_DEF; k++) begin
              dot += longint'(mat_a[r * DIM_DEF + k]) * longint'(mat_b[k * DIM_DEF + c]);
            end
            ent.row  = ROW_W'(r);
            ent.col  = COL_W'(c);
            ent.sum  = SUM_W'(longint'(mat_a[idx]) + longint'(mat_b[idx]));
            ent.diff = DIFF_W'(longint'(mat_a[idx]) - longint'(mat_b[idx]));
            ent.prod = PROD_W'(dot);
            ent.last = (idx == CELLS - 1);
            matrix_entries_q.push_back(ent);
          end
        end
        elems_loaded = 0;
      end
    end

    // result transfer: compare against the oldest predicted entry
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (matrix_entries_q.size() == 0) begin
        $error("unexpected result: row %0d col %0d", out_mon.row_index, out_mon.col_index);
        fail_count++;
      end else begin
        ent = matrix_entries_q.pop_front();
        if (out_mon.row_index !== ent.row) begin
          $error("row_index mismatch: expected %0d, actual %0d", ent.row, out_mon.row_index);
          fail_count++;
        end
        if (out_mon.col_index !== ent.col) begin
          $error("col_index mismatch: expected %0d, actual %0d", ent.col, out_mon.col_index);
          fail_count++;
        end
        if (out_mon.sum_value !== ent.sum) begin
          $error("sum_value mismatch: expected %0d, actual %0d", ent.sum, out_mon.sum_value);
          fail_count++;
        end
        if (out_mon.diff_value !== ent.diff) begin
          $error("diff_value mismatch: expected %0d, actual %0d", ent.diff,
                 out_mon.diff_value);
          fail_count++;
        end
        if (out_mon.product_value !== ent.prod) begin
          $error("product_value mismatch: expected %0d, actual %0d", ent.prod,
                 out_mon.product_value);
          fail_count++;
        end
        if (out_mon.last_entry !== ent.last) begin
          $error("last_entry mismatch: expected %0d, actual %0d", ent.last,
                 out_mon.last_entry);
          fail_count++;
        end
      end
    end

    // nonblocking update, so the stimulus sees no race with the pushes above
    pending_count <= matrix_entries_q.size();
  end

endmodule

>>> tb/matrix_sum_diff_product_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_sum_diff_product_3x3_tb: top-level test of the matrix block
// Streams pairs of 3x3 matrices in, first a corner-value pair, then random
// pairs under random source gaps and sink stalls, a back-to-back stretch, a
// long sink hold-off and a source pause. A checker module scores the results.
// ----------------------------------------------------------------------------
module matrix_sum_diff_product_3x3_tb;
  import msdp_pkg::*;

  localparam int unsigned CELLS        = DIM_DEF * DIM_DEF;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 32;

  // corner pair: row 0 of A and column 0 of B all most negative (largest
  // product), row 1 of A and column 1 of B all most positive, opposite
  // extremes for the extreme sums and differences, plus zero, one and -1
  localparam logic signed [ELEM_WIDTH_DEF-1:0] CORNER_PAIR [2*CELLS] = '{
    16'sh8000, 16'sh8000, 16'sh8000,
    16'sh7fff, 16'sh7fff, 16'sh7fff,
    16'sh8000, 16'sh0000, 16'sh0001,
    16'sh8000, 16'sh7fff, 16'shffff,
    16'sh8000, 16'sh7fff, 16'sh0000,
    16'sh8000, 16'sh7fff, 16'sh8000
  };

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        tx_idle_en  = 1'b1;
  logic        rx_idle_en  = 1'b1;
  logic        rx_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  int          fail_count;
  int          pending_count;

  msdp_in_if  in_ch ();
  msdp_out_if out_ch ();

  matrix_sum_diff_product_3x3 u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msdp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one element: optional gap, then hold valid until the transfer
  task automatic send_element(input logic signed [ELEM_WIDTH_DEF-1:0] value);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // random element, biased toward the extremes and the all-zero/all-one words
  function automatic logic signed [ELEM_WIDTH_DEF-1:0] random_element();
    case ($urandom_range(0, 15))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return ELEM_WIDTH_DEF'($urandom());
    endcase
  endfunction

  task automatic send_random_pair();
    repeat (2 * CELLS) send_element(random_element());
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      stall = rx_idle_en ? $urandom_range(0, 15) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready) && !rx_hold_req);
    end
  end

  // element stimulus and verdict
  initial begin : element_source
    in_ch.valid         = 1'b0;
    in_ch.element_value = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (CORNER_PAIR[i]) send_element(CORNER_PAIR[i]);
    repeat (4) send_random_pair();

    // back-to-back on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (2) send_random_pair();

    // sink holds off while the source keeps offering, so the input stalls
    rx_hold_req = 1'b1;
    repeat (3) send_random_pair();

    // source pauses until every result has drained
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);

    repeat (3) send_random_pair();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
